@@ rtl/bwdc_pkg.sv @@
package bwdc_pkg;

    localparam int BYTE_BITS = 8;
    localparam int SUM_W     = 16;
    localparam int DIGIT_W   = 8;
    localparam int LOG_W_W   = 4;
    localparam int SHIFT_W   = 7;   // (16 - 1) * 8 fits
    localparam int BITS_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG_W           = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_DIGITS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_DIGITS = 2'd2;

    localparam logic [LOG_W_W-1:0] LOG_W_RESET           = 4'd4;
    localparam logic [8:0]         MSG_DIGITS_RESET      = 9'd64;
    localparam logic [4:0]         CHECKSUM_DIGITS_RESET = 5'd3;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SPLIT = 3'b010,
        ST_CSUM  = 3'b100
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic emit_msg;
        logic csum_start;
        logic emit_csum;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic count_done;
        logic final_msg;
        logic more_digits;
        logic csum_last;
    } status_t;

endpackage

@@ rtl/base_w_digits_with_checksum.sv @@
// Base-w digit splitter with Winternitz checksum.
// Input channel (s_valid/s_ready, s_hash_byte): message-hash bytes in order,
// most significant bit first. Result channel (m_valid/m_ready): one digit per
// transfer with m_is_checksum and m_last flags. Configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) writes log_w (0), msg_digits (1)
// and checksum_digits (2); cfg_ready is always high. Write it only while idle.
// A byte is accepted in ST_IDLE, then split in ST_SPLIT into message digits
// (floor of buffered bits over log_w, up to 8 at log_w = 1). After the last
// message digit the checksum digits follow, one per cycle while the receiver
// takes them. The rate is set by the single output register, which takes one
// digit per cycle when not stalled; a new byte is taken only once the current
// one is fully split. When the receiver stalls, the block holds the pending
// digit and waits.
// Reset (aresetn low, synchronous) clears the bit buffer, digit count and
// checksum, drops any pending result and restores the register defaults
// (log_w 4, msg_digits 64, checksum_digits 3).
module base_w_digits_with_checksum #(
    parameter int MAX_MSG_DIGITS      = 256,
    parameter int MAX_CHECKSUM_DIGITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bwdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bwdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bwdc_pkg::BYTE_BITS-1:0]      s_hash_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bwdc_pkg::DIGIT_W-1:0]        m_digit,
    output logic                                m_is_checksum,
    output logic                                m_last
);
    import bwdc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    bwdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bwdc_datapath #(
        .MAX_MSG_DIGITS      (MAX_MSG_DIGITS),
        .MAX_CHECKSUM_DIGITS (MAX_CHECKSUM_DIGITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write     (cfg_valid & cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_hash_byte   (s_hash_byte),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digit       (m_digit),
        .m_is_checksum (m_is_checksum),
        .m_last        (m_last)
    );

endmodule

@@ rtl/bwdc_ctrl.sv @@
module bwdc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bwdc_pkg::status_t status,
    output bwdc_pkg::cmd_t    cmd
);
    import bwdc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_byte = 1'b1;
                    // digit quota already met: the byte yields no digit, checksum follows
                    if (status.count_done) begin
                        cmd.csum_start = 1'b1;
                        state_next     = ST_CSUM;
                    end else begin
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                if (status.slot_free) begin
                    cmd.emit_msg = 1'b1;
                    if (status.final_msg) begin
                        cmd.csum_start = 1'b1;
                        state_next     = ST_CSUM;
                    end else if (!status.more_digits) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CSUM: begin
                if (status.slot_free) begin
                    cmd.emit_csum = 1'b1;
                    if (status.csum_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/bwdc_datapath.sv @@
module bwdc_datapath #(
    parameter int MAX_MSG_DIGITS      = 256,
    parameter int MAX_CHECKSUM_DIGITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write,
    input  logic [bwdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bwdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [bwdc_pkg::BYTE_BITS-1:0]      s_hash_byte,
    input  bwdc_pkg::cmd_t                      cmd,
    output bwdc_pkg::status_t                   status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bwdc_pkg::DIGIT_W-1:0]        m_digit,
    output logic                                m_is_checksum,
    output logic                                m_last
);
    import bwdc_pkg::*;

    localparam int CNT_W = $clog2(MAX_MSG_DIGITS + 1);
    localparam int CK_W  = $clog2(MAX_CHECKSUM_DIGITS + 1);

    // configuration
    logic [LOG_W_W-1:0] log_w_reg;
    logic [8:0]         msg_digits_reg;
    logic [4:0]         checksum_digits_reg;

    logic [LOG_W_W-1:0] lw_eff;
    logic [CNT_W-1:0]   md_eff;
    logic [CK_W-1:0]    cd_eff;
    logic [DIGIT_W-1:0] mask;

    // message state
    logic [SUM_W-1:0]   bitbuf_reg, bitbuf_next;
    logic [BITS_W-1:0]  bits_reg, bits_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [CK_W-1:0]    remain_reg, remain_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [DIGIT_W-1:0] m_digit_reg, m_digit_next;
    logic               m_is_checksum_reg, m_is_checksum_next;
    logic               m_last_reg, m_last_next;

    logic [BITS_W-1:0]  bits_left;
    logic [SUM_W-1:0]   msg_field;
    logic [DIGIT_W-1:0] msg_digit;
    logic [SUM_W-1:0]   csum_field;
    logic [DIGIT_W-1:0] csum_digit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_w_reg           <= LOG_W_RESET;
            msg_digits_reg      <= MSG_DIGITS_RESET;
            checksum_digits_reg <= CHECKSUM_DIGITS_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_LOG_W:           log_w_reg           <= cfg_data[LOG_W_W-1:0];
                CFG_MSG_DIGITS:      msg_digits_reg      <= cfg_data[8:0];
                CFG_CHECKSUM_DIGITS: checksum_digits_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // clamp registers to their usable ranges
    always_comb begin
        if (log_w_reg == '0) begin
            lw_eff = LOG_W_W'(1);
        end else if (log_w_reg > LOG_W_W'(8)) begin
            lw_eff = LOG_W_W'(8);
        end else begin
            lw_eff = log_w_reg;
        end

        if (msg_digits_reg == '0) begin
            md_eff = CNT_W'(1);
        end else if (int'(msg_digits_reg) > MAX_MSG_DIGITS) begin
            md_eff = CNT_W'(MAX_MSG_DIGITS);
        end else begin
            md_eff = CNT_W'(msg_digits_reg);
        end

        if (checksum_digits_reg == '0) begin
            cd_eff = CK_W'(1);
        end else if (int'(checksum_digits_reg) > MAX_CHECKSUM_DIGITS) begin
            cd_eff = CK_W'(MAX_CHECKSUM_DIGITS);
        end else begin
            cd_eff = CK_W'(checksum_digits_reg);
        end
    end

    assign mask = DIGIT_W'((9'd1 << lw_eff) - 9'd1);

    assign bits_left  = bits_reg - lw_eff;
    assign msg_field  = (bitbuf_reg >> bits_left) & {8'd0, mask};
    assign msg_digit  = msg_field[DIGIT_W-1:0];
    assign csum_field = (sum_reg >> shift_reg[3:0]) & {8'd0, mask};
    assign csum_digit = (shift_reg < SHIFT_W'(SUM_W)) ? csum_field[DIGIT_W-1:0] : '0;

    always_comb begin
        status.slot_free   = !m_valid_reg || m_ready;
        status.count_done  = count_reg >= md_eff;
        status.final_msg   = ({1'b0, count_reg} + 1'b1) >= {1'b0, md_eff};
        status.more_digits = bits_left >= lw_eff;
        status.csum_last   = remain_reg == '0;
    end

    always_comb begin
        bitbuf_next = bitbuf_reg;
        bits_next   = bits_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        shift_next  = shift_reg;
        remain_next = remain_reg;

        m_valid_next       = m_valid_reg && !m_ready;
        m_digit_next       = m_digit_reg;
        m_is_checksum_next = m_is_checksum_reg;
        m_last_next        = m_last_reg;

        if (cmd.load_byte) begin
            bitbuf_next = {bitbuf_reg[BYTE_BITS-1:0], s_hash_byte};
            bits_next   = bits_reg + BITS_W'(BYTE_BITS);
        end

        if (cmd.emit_msg) begin
            bitbuf_next        = bitbuf_reg & ((16'd1 << bits_left) - 16'd1);
            bits_next          = bits_left;
            count_next         = count_reg + 1'b1;
            sum_next           = sum_reg + {8'd0, mask} - {8'd0, msg_digit};
            m_valid_next       = 1'b1;
            m_digit_next       = msg_digit;
            m_is_checksum_next = 1'b0;
            m_last_next        = 1'b0;
        end

        // top checksum digit sits at (checksum_digits - 1) * log_w
        if (cmd.csum_start) begin
            shift_next  = SHIFT_W'(cd_eff - 1'b1) * SHIFT_W'(lw_eff);
            remain_next = cd_eff - 1'b1;
        end

        if (cmd.emit_csum) begin
            shift_next         = shift_reg - SHIFT_W'(lw_eff);
            remain_next        = remain_reg - 1'b1;
            m_valid_next       = 1'b1;
            m_digit_next       = csum_digit;
            m_is_checksum_next = 1'b1;
            m_last_next        = status.csum_last;
            // message done: drop leftover bit buffer, bit count, digit count and sum
            if (status.csum_last) begin
                bitbuf_next = '0;
                bits_next   = '0;
                count_next  = '0;
                sum_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitbuf_reg  <= '0;
            bits_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            bitbuf_reg  <= bitbuf_next;
            bits_reg    <= bits_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg         <= shift_next;
        remain_reg        <= remain_next;
        m_digit_reg       <= m_digit_next;
        m_is_checksum_reg <= m_is_checksum_next;
        m_last_reg        <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_digit       = m_digit_reg;
    assign m_is_checksum = m_is_checksum_reg;
    assign m_last        = m_last_reg;

endmodule
